// ===== sv/bdch_pkg.sv =====
// Package for the button debouncer with click and hold detection.
// Holds widths, register indexes, reset values and the item layouts.
// Depends on nothing; used by button_debounce_click_hold_top.
package bdch_pkg;

   localparam int TIME_BITS  = 32;
   localparam int COUNT_BITS = 16;
   localparam int CFG_BITS   = 16;
   localparam int ADDR_BITS  = 2;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 40;

   // Register indexes on the csr_ port
   localparam logic [ADDR_BITS-1:0] REG_PRESSED_LEVEL   = 2'd0;
   localparam logic [ADDR_BITS-1:0] REG_DEBOUNCE_MS     = 2'd1;
   localparam logic [ADDR_BITS-1:0] REG_DOUBLE_CLICK_MS = 2'd2;
   localparam logic [ADDR_BITS-1:0] REG_HOLD_MS         = 2'd3;

   // Item kinds carried on req_tuser
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // Register reset values
   localparam logic                RST_PRESSED_LEVEL   = 1'b1;
   localparam logic [CFG_BITS-1:0] RST_DEBOUNCE_MS     = 16'd30;
   localparam logic [CFG_BITS-1:0] RST_DOUBLE_CLICK_MS = 16'd400;
   localparam logic [CFG_BITS-1:0] RST_HOLD_MS         = 16'd1000;

   // Clear mask bits on a read
   localparam int CLR_PRESS   = 0;
   localparam int CLR_RELEASE = 1;
   localparam int CLR_CHANGE  = 2;

   typedef struct packed {
      logic [3:0]           pad;
      logic [2:0]           clear_mask;
      logic                 pin_level;
      logic [TIME_BITS-1:0] now_ms;
   } req_data_type;

   typedef struct packed {
      logic [1:0]            pad;
      logic [COUNT_BITS-1:0] releases;
      logic [COUNT_BITS-1:0] presses;
      logic                  is_pressed;
      logic                  holding;
      logic                  double_click;
      logic                  change_event;
      logic                  release_event;
      logic                  press_event;
   } rsp_data_type;

endpackage

// ===== sv/button_debounce_click_hold_top.sv =====
// Top level of the button debouncer with click and hold detection.
// Debounce state, event flags, counters and the result register.
// Depends on bdch_pkg.
//
// Usage:
//   Each item on the req_ channel is either a pin sample (req_tuser = 0,
//   with time stamp and raw pin level) or a status read (req_tuser = 1,
//   with a clear mask). Every item returns exactly one status item on the
//   rsp_ channel. A sample reports the status after the sample is applied;
//   a read reports the status and then drops the sticky flags chosen by
//   its clear mask.
//   The item accepted shows on rsp_ in the next cycle. Throughput is one
//   item per cycle while the receiver takes each item; it is set by the single
//   result register, which is refilled in the same cycle it is emptied.
//   When the receiver stalls, the result register holds its item and
//   req_tready drops until rsp_tready returns.
//   Reset (synchronous, active high) clears all debounce state, flags,
//   counters and time stamps and loads the register defaults: pressed
//   level 1, debounce 30 ms, double click 400 ms, hold 1000 ms.
//   Write the csr_ registers only while the block is idle.
module button_debounce_click_hold_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write port
   input  logic                                  csr_we,
   input  logic [bdch_pkg::ADDR_BITS-1:0]        csr_addr,
   input  logic [bdch_pkg::CFG_BITS-1:0]         csr_wdata,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: now_ms[31:0], pin_level[32], clear_mask[35:33], zero pad
   input  logic [bdch_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // tuser: op (0 sample, 1 read)
   input  logic                                  req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: press_event[0], release_event[1], change_event[2],
   //        double_click[3], holding[4], is_pressed[5],
   //        presses[21:6], releases[37:22], zero pad
   output logic [bdch_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);

   localparam int TB = bdch_pkg::TIME_BITS;
   localparam int CB = bdch_pkg::COUNT_BITS;
   localparam int WB = bdch_pkg::CFG_BITS;

   // configuration registers
   logic          pressed_level_ff;
   logic [WB-1:0] debounce_ms_ff;
   logic [WB-1:0] double_click_ms_ff;
   logic [WB-1:0] hold_ms_ff;

   // debounce and event state
   logic          prev_raw_ff,      prev_raw_in;
   logic          stable_level_ff,  stable_level_in;
   logic          timer_armed_ff,   timer_armed_in;
   logic [TB-1:0] timer_start_ff,   timer_start_in;
   logic          down_ff,          down_in;
   logic          change_flag_ff,   change_flag_in;
   logic          press_flag_ff,    press_flag_in;
   logic          release_flag_ff,  release_flag_in;
   logic [CB-1:0] press_total_ff,   press_total_in;
   logic [CB-1:0] release_total_ff, release_total_in;
   logic [TB-1:0] press_time_ff,    press_time_in;
   logic [TB-1:0] release_time_ff,  release_time_in;
   logic [TB-1:0] prior_rel_ff,     prior_rel_in;
   logic [TB-1:0] last_sample_ff,   last_sample_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   bdch_pkg::rsp_data_type rsp_data_ff,  rsp_data_in;

   bdch_pkg::req_data_type req;
   logic                   req_fire;
   logic                   is_sample;
   logic [TB-1:0]          elapsed;
   logic [TB-1:0]          rel_gap;
   logic [TB-1:0]          held_for;
   logic                   accept_lvl;
   logic                   lvl_changed;

   assign req        = bdch_pkg::req_data_type'(req_tdata);
   // The result register frees up in the same cycle it is drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_sample  = (req_tuser == bdch_pkg::OP_SAMPLE);
   assign elapsed    = req.now_ms - timer_start_ff;

   // Next state for one item, then the status it reports.
   always_comb begin
      prev_raw_in      = prev_raw_ff;
      stable_level_in  = stable_level_ff;
      timer_armed_in   = timer_armed_ff;
      timer_start_in   = timer_start_ff;
      down_in          = down_ff;
      change_flag_in   = change_flag_ff;
      press_flag_in    = press_flag_ff;
      release_flag_in  = release_flag_ff;
      press_total_in   = press_total_ff;
      release_total_in = release_total_ff;
      press_time_in    = press_time_ff;
      release_time_in  = release_time_ff;
      prior_rel_in     = prior_rel_ff;
      last_sample_in   = last_sample_ff;
      accept_lvl       = 1'b0;
      lvl_changed      = 1'b0;

      if (is_sample) begin
         if (req.pin_level != prev_raw_ff) begin
            // Raw edge: restart the debounce timer.
            timer_start_in = req.now_ms;
            timer_armed_in = 1'b1;
         end else if (timer_armed_ff && (elapsed > TB'(debounce_ms_ff))) begin
            accept_lvl = 1'b1;
         end
         last_sample_in = req.now_ms;
         prev_raw_in    = req.pin_level;
      end

      if (accept_lvl) begin
         lvl_changed     = (stable_level_ff != req.pin_level);
         timer_armed_in  = 1'b0;
         stable_level_in = req.pin_level;
         down_in         = (req.pin_level == pressed_level_ff);
         if (lvl_changed) begin
            change_flag_in = 1'b1;
            if (down_in) begin
               press_flag_in   = 1'b1;
               release_flag_in = 1'b0;
               press_total_in  = press_total_ff + CB'(1);
               press_time_in   = req.now_ms;
            end else begin
               press_flag_in    = 1'b0;
               release_flag_in  = 1'b1;
               release_total_in = release_total_ff + CB'(1);
               prior_rel_in     = release_time_ff;
               release_time_in  = req.now_ms;
            end
         end else begin
            // Same level accepted again: drop all sticky events.
            change_flag_in  = 1'b0;
            press_flag_in   = 1'b0;
            release_flag_in = 1'b0;
         end
      end

      rel_gap  = release_time_in - prior_rel_in;
      held_for = last_sample_in - press_time_in;

      rsp_data_in               = '0;
      rsp_data_in.press_event   = press_flag_in;
      rsp_data_in.release_event = release_flag_in;
      rsp_data_in.change_event  = change_flag_in;
      rsp_data_in.double_click  = release_flag_in && (rel_gap <= TB'(double_click_ms_ff));
      rsp_data_in.holding       = down_in && (held_for > TB'(hold_ms_ff));
      rsp_data_in.is_pressed    = down_in;
      rsp_data_in.presses       = press_total_in;
      rsp_data_in.releases      = release_total_in;

      // A read drops the selected sticky flags after reporting them.
      if (!is_sample) begin
         if (req.clear_mask[bdch_pkg::CLR_PRESS])   press_flag_in   = 1'b0;
         if (req.clear_mask[bdch_pkg::CLR_RELEASE]) release_flag_in = 1'b0;
         if (req.clear_mask[bdch_pkg::CLR_CHANGE])  change_flag_in  = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_level_ff   <= bdch_pkg::RST_PRESSED_LEVEL;
         debounce_ms_ff     <= bdch_pkg::RST_DEBOUNCE_MS;
         double_click_ms_ff <= bdch_pkg::RST_DOUBLE_CLICK_MS;
         hold_ms_ff         <= bdch_pkg::RST_HOLD_MS;
      end else if (csr_we) begin
         unique case (csr_addr)
            bdch_pkg::REG_PRESSED_LEVEL:   pressed_level_ff   <= csr_wdata[0];
            bdch_pkg::REG_DEBOUNCE_MS:     debounce_ms_ff     <= csr_wdata;
            bdch_pkg::REG_DOUBLE_CLICK_MS: double_click_ms_ff <= csr_wdata;
            bdch_pkg::REG_HOLD_MS:         hold_ms_ff         <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Debounce state: advance only on an accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff      <= 1'b0;
         stable_level_ff  <= 1'b0;
         timer_armed_ff   <= 1'b0;
         timer_start_ff   <= '0;
         down_ff          <= 1'b0;
         change_flag_ff   <= 1'b0;
         press_flag_ff    <= 1'b0;
         release_flag_ff  <= 1'b0;
         press_total_ff   <= '0;
         release_total_ff <= '0;
         press_time_ff    <= '0;
         release_time_ff  <= '0;
         prior_rel_ff     <= '0;
         last_sample_ff   <= '0;
      end else if (req_fire) begin
         prev_raw_ff      <= prev_raw_in;
         stable_level_ff  <= stable_level_in;
         timer_armed_ff   <= timer_armed_in;
         timer_start_ff   <= timer_start_in;
         down_ff          <= down_in;
         change_flag_ff   <= change_flag_in;
         press_flag_ff    <= press_flag_in;
         release_flag_ff  <= release_flag_in;
         press_total_ff   <= press_total_in;
         release_total_ff <= release_total_in;
         press_time_ff    <= press_time_in;
         release_time_ff  <= release_time_in;
         prior_rel_ff     <= prior_rel_in;
         last_sample_ff   <= last_sample_in;
      end
   end

   // Result register: hold while stalled, load on every accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
